@@ rtl/core/vpa_pkg.sv @@
package vpa_pkg;

    localparam int CORDIC_ITER_DEF = 16;

    // cordic datapath: x/y carry 24 guard bits below Q16.16, angles are degrees * 2^24
    localparam int GUARD = 24;
    localparam int CW    = 60;
    localparam int ZW    = 36;
    localparam int DQW   = 48;
    localparam int SQW   = 64;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 24;
    localparam int ANG_STEPS = 8;

    localparam logic [32:0] ANG_FULL = 33'd23592960;
    localparam logic [32:0] ANG_HALF = 33'd11796480;

    localparam logic signed [ZW-1:0] DEG90  = 36'sd1509949440;
    localparam logic signed [ZW-1:0] DEG180 = 36'sd3019898880;
    localparam logic signed [ZW-1:0] Q180   = 36'sd11796480;
    localparam logic signed [ZW-1:0] Q360   = 36'sd23592960;

    localparam logic signed [32:0] INV_GAIN = 33'sd2608131496;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_SCALE   = 4'd2,
        OP_MUL     = 4'd3,
        OP_DIVS    = 4'd4,
        OP_DIV     = 4'd5,
        OP_TOPOL   = 4'd6,
        OP_FROMPOL = 4'd7,
        OP_SETANG  = 4'd8
    } t_op;

    typedef struct packed {
        logic                    valid;
        logic [3:0]              op;
        logic signed [31:0]      ax;
        logic signed [31:0]      ay;
        logic signed [63:0]      p0;
        logic signed [63:0]      p1;
        logic [SQW-1:0]          sq_v;
        logic [SQW-1:0]          sq_r;
        logic [DQW-1:0]          dqx;
        logic [DQW-1:0]          dqy;
        logic [31:0]             drx;
        logic [31:0]             dry;
        logic [31:0]             ddx;
        logic [31:0]             ddy;
        logic                    dsx;
        logic                    dsy;
        logic                    dzx;
        logic                    dzy;
        logic                    dpx;
        logic                    dpy;
        logic                    dmx;
        logic                    dmy;
        logic                    ang_neg;
        logic [32:0]             ang_rem;
        logic signed [31:0]      res_x;
        logic signed [31:0]      res_y;
        logic                    res_dz;
        logic signed [66:0]      gprod;
        logic                    flip;
        logic                    vmode;
        logic                    zvec;
        logic signed [CW-1:0]    cx;
        logic signed [CW-1:0]    cy;
        logic signed [ZW-1:0]    cz;
    } t_stage;

    typedef struct packed {
        logic [DQW-1:0] q;
        logic [31:0]    r;
    } t_div;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] r;
    } t_sq;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < 68'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // two restoring division bits
    function automatic t_div div_step2(input t_div s, input logic [31:0] d);
        t_div        o;
        logic [32:0] rm;
        logic        ge;
        o = s;
        for (int b = 0; b < 2; b++) begin
            rm  = {o.r, o.q[DQW-1]};
            ge  = rm >= {1'b0, d};
            o.r = ge ? 32'(rm - {1'b0, d}) : rm[31:0];
            o.q = {o.q[DQW-2:0], ge};
        end
        return o;
    endfunction

    function automatic t_sq sq_step(input t_sq s, input logic [SQW-1:0] b);
        t_sq         o;
        logic [64:0] t;
        o = s;
        t = {1'b0, s.r} + {1'b0, b};
        if ({1'b0, s.v} >= t) begin
            o.v = s.v - t[63:0];
            o.r = (s.r >> 1) + b;
        end else begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // atan(2^-i) in degrees * 2^24
    function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
        case (i)
            0:  return 36'sd754974720;
            1:  return 36'sd445687602;
            2:  return 36'sd235489088;
            3:  return 36'sd119537938;
            4:  return 36'sd60000934;
            5:  return 36'sd30029717;
            6:  return 36'sd15018523;
            7:  return 36'sd7509720;
            8:  return 36'sd3754917;
            9:  return 36'sd1877466;
            10: return 36'sd938734;
            11: return 36'sd469367;
            12: return 36'sd234684;
            13: return 36'sd117342;
            14: return 36'sd58671;
            15: return 36'sd29335;
            16: return 36'sd14668;
            17: return 36'sd7334;
            18: return 36'sd3667;
            19: return 36'sd1833;
            20: return 36'sd917;
            21: return 36'sd458;
            22: return 36'sd229;
            23: return 36'sd115;
            24: return 36'sd57;
            25: return 36'sd29;
            26: return 36'sd14;
            27: return 36'sd7;
            28: return 36'sd4;
            29: return 36'sd2;
            30: return 36'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/core/vector2d_polar_arith_unit.sv @@
// Fully pipelined 2D vector unit, signed Q16.16, angles in degrees. A start beat is taken
// in every cycle (busy stays low) and its result strobes on o_valid in issue order; the
// output cannot be held off, so the receiver must take each result in its strobe cycle.
// The pipeline depth is set by the 32-stage bit-serial square root feeding the gain
// multiplier and one CORDIC stage per iteration; the 48-bit dividers and angle reduction
// run alongside the square root.
module vector2d_polar_arith_unit
    import vpa_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    output logic               o_valid,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic               o_div_zero
);

    localparam int K_DIV_FIN = 2 + DIV_STEPS;
    localparam int K_ANG_FIN = 2 + ANG_STEPS;
    localparam int K_FOLD    = K_ANG_FIN + 1;
    localparam int K_SQ0     = 3;
    localparam int K_SQ_FIN  = K_SQ0 + SQ_STEPS;
    localparam int K_GMUL    = K_SQ_FIN + 1;
    localparam int K_CPREP   = K_GMUL + 1;
    localparam int K_C0      = K_CPREP + 1;
    localparam int NS        = K_C0 + CORDIC_ITERATIONS - 1;

    logic               r_in_valid;
    logic [3:0]         r_in_op;
    logic signed [31:0] r_in_ax;
    logic signed [31:0] r_in_ay;
    logic signed [31:0] r_in_bx;
    logic signed [31:0] r_in_by;

    t_stage r_st [1:NS];
    t_stage n_st [1:NS];

    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic               r_out_dz;
    logic signed [31:0] n_out_x;
    logic signed [31:0] n_out_y;
    logic               n_out_dz;
    logic signed [ZW-1:0] q_ang;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        r_in_op <= i_opcode;
        r_in_ax <= i_a_x;
        r_in_ay <= i_a_y;
        r_in_bx <= i_b_x;
        r_in_by <= i_b_y;
    end

    // operand prep: shared multipliers, divider setup, angle magnitude, add/sub
    always_comb begin
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] divy;
        logic signed [31:0] ang;
        n_st[1]       = r_st[1];
        n_st[1].valid = r_in_valid;
        n_st[1].op    = r_in_op;
        n_st[1].ax    = r_in_ax;
        n_st[1].ay    = r_in_ay;
        m0 = (r_in_op == OP_SCALE || r_in_op == OP_MUL) ? r_in_bx : r_in_ax;
        m1 = (r_in_op == OP_SCALE) ? r_in_bx : ((r_in_op == OP_MUL) ? r_in_by : r_in_ay);
        n_st[1].p0 = 64'(r_in_ax) * 64'(m0);
        n_st[1].p1 = 64'(r_in_ay) * 64'(m1);

        divy = (r_in_op == OP_DIVS) ? r_in_bx : r_in_by;
        n_st[1].dqx = {mag32(r_in_ax), 16'd0};
        n_st[1].dqy = {mag32(r_in_ay), 16'd0};
        n_st[1].drx = '0;
        n_st[1].dry = '0;
        n_st[1].ddx = mag32(r_in_bx);
        n_st[1].ddy = mag32(divy);
        n_st[1].dsx = r_in_ax[31] ^ r_in_bx[31];
        n_st[1].dsy = r_in_ay[31] ^ divy[31];
        n_st[1].dzx = (r_in_bx == 32'sd0);
        n_st[1].dzy = (divy == 32'sd0);
        n_st[1].dpx = !r_in_ax[31] && (r_in_ax != 32'sd0);
        n_st[1].dpy = !r_in_ay[31] && (r_in_ay != 32'sd0);
        n_st[1].dmx = r_in_ax[31];
        n_st[1].dmy = r_in_ay[31];

        ang = (r_in_op == OP_FROMPOL) ? r_in_ay : r_in_bx;
        n_st[1].ang_neg = ang[31];
        n_st[1].ang_rem = {1'b0, mag32(ang)};

        n_st[1].res_dz = 1'b0;
        case (r_in_op)
            OP_ADD: begin
                n_st[1].res_x = sat32(68'(r_in_ax) + 68'(r_in_bx));
                n_st[1].res_y = sat32(68'(r_in_ay) + 68'(r_in_by));
            end
            OP_SUB: begin
                n_st[1].res_x = sat32(68'(r_in_ax) - 68'(r_in_bx));
                n_st[1].res_y = sat32(68'(r_in_ay) - 68'(r_in_by));
            end
            default: begin
                n_st[1].res_x = '0;
                n_st[1].res_y = '0;
            end
        endcase
        n_st[1].flip  = 1'b0;
        n_st[1].vmode = 1'b0;
        n_st[1].zvec  = 1'b0;
    end

    genvar k;
    generate
        for (k = 2; k <= NS; k++) begin : g_stage
            always_comb begin
                t_div               dv;
                t_sq                sq;
                logic signed [33:0] m;
                logic signed [33:0] src;
                logic signed [CW-1:0] x0;
                logic signed [CW-1:0] y0;
                logic signed [CW-1:0] dx;
                logic signed [CW-1:0] dy;
                logic               up;
                n_st[k] = r_st[k-1];
                dv  = '0;
                sq  = '0;
                m   = '0;
                src = '0;
                x0  = '0;
                y0  = '0;
                dx  = '0;
                dy  = '0;
                up  = 1'b0;

                if (k == 2) begin
                    n_st[k].sq_v = SQW'(r_st[k-1].p0) + SQW'(r_st[k-1].p1);
                    n_st[k].sq_r = '0;
                    if (r_st[k-1].op == OP_SCALE || r_st[k-1].op == OP_MUL) begin
                        n_st[k].res_x = sat32(68'((r_st[k-1].p0 + 64'sd32768) >>> 16));
                        n_st[k].res_y = sat32(68'((r_st[k-1].p1 + 64'sd32768) >>> 16));
                    end
                end

                // quotient bits, two per stage
                if (k >= 2 && k < 2 + DIV_STEPS) begin
                    dv = div_step2({r_st[k-1].dqx, r_st[k-1].drx}, r_st[k-1].ddx);
                    n_st[k].dqx = dv.q;
                    n_st[k].drx = dv.r;
                    dv = div_step2({r_st[k-1].dqy, r_st[k-1].dry}, r_st[k-1].ddy);
                    n_st[k].dqy = dv.q;
                    n_st[k].dry = dv.r;
                end

                if (k == K_DIV_FIN &&
                    (r_st[k-1].op == OP_DIVS || r_st[k-1].op == OP_DIV)) begin
                    if (r_st[k-1].dzx) begin
                        n_st[k].res_x = r_st[k-1].dpx ? S32_MAX :
                                        (r_st[k-1].dmx ? S32_MIN : 32'sd0);
                    end else begin
                        n_st[k].res_x = sat32(r_st[k-1].dsx ? -68'(r_st[k-1].dqx)
                                                             :  68'(r_st[k-1].dqx));
                    end
                    if (r_st[k-1].dzy) begin
                        n_st[k].res_y = r_st[k-1].dpy ? S32_MAX :
                                        (r_st[k-1].dmy ? S32_MIN : 32'sd0);
                    end else begin
                        n_st[k].res_y = sat32(r_st[k-1].dsy ? -68'(r_st[k-1].dqy)
                                                             :  68'(r_st[k-1].dqy));
                    end
                    n_st[k].res_dz = r_st[k-1].dzx | r_st[k-1].dzy;
                end

                // angle mod 360: subtract 360 * 2^i, largest first
                if (k >= 2 && k < 2 + ANG_STEPS) begin
                    if (r_st[k-1].ang_rem >= (ANG_FULL << (ANG_STEPS + 1 - k))) begin
                        n_st[k].ang_rem = r_st[k-1].ang_rem -
                                          (ANG_FULL << (ANG_STEPS + 1 - k));
                    end
                end

                if (k == K_ANG_FIN) begin
                    if (r_st[k-1].ang_neg && r_st[k-1].ang_rem != '0) begin
                        m = $signed({1'b0, ANG_FULL - r_st[k-1].ang_rem});
                    end else begin
                        m = $signed({1'b0, r_st[k-1].ang_rem});
                    end
                    if (m > $signed({1'b0, ANG_HALF})) begin
                        m = m - $signed({1'b0, ANG_FULL});
                    end
                    n_st[k].cz = ZW'(m) <<< (GUARD - 16);
                end

                // fold into [-90,90], the sign of x follows later
                if (k == K_FOLD) begin
                    if (r_st[k-1].cz > DEG90) begin
                        n_st[k].cz   = r_st[k-1].cz - DEG180;
                        n_st[k].flip = 1'b1;
                    end else if (r_st[k-1].cz < -DEG90) begin
                        n_st[k].cz   = r_st[k-1].cz + DEG180;
                        n_st[k].flip = 1'b1;
                    end
                end

                if (k >= K_SQ0 && k < K_SQ_FIN) begin
                    sq = sq_step({r_st[k-1].sq_v, r_st[k-1].sq_r},
                                 SQW'(1) << (2 * (SQ_STEPS - 1) - 2 * (k - K_SQ0)));
                    n_st[k].sq_v = sq.v;
                    n_st[k].sq_r = sq.r;
                end

                if (k == K_SQ_FIN) begin
                    if (r_st[k-1].sq_v > r_st[k-1].sq_r) begin
                        n_st[k].sq_r = r_st[k-1].sq_r + SQW'(1);
                    end
                end

                if (k == K_GMUL) begin
                    src = (r_st[k-1].op == OP_FROMPOL) ? 34'(r_st[k-1].ax)
                                                       : $signed({1'b0, r_st[k-1].sq_r[32:0]});
                    n_st[k].gprod = 67'(src) * 67'(INV_GAIN);
                end

                if (k == K_CPREP) begin
                    if (r_st[k-1].op == OP_TOPOL) begin
                        x0 = CW'(r_st[k-1].ax) <<< GUARD;
                        y0 = CW'(r_st[k-1].ay) <<< GUARD;
                        n_st[k].vmode = 1'b1;
                        n_st[k].zvec  = (r_st[k-1].ax == 32'sd0) && (r_st[k-1].ay == 32'sd0);
                        if (!r_st[k-1].ax[31]) begin
                            n_st[k].cx = x0;
                            n_st[k].cy = y0;
                            n_st[k].cz = '0;
                        end else if (!r_st[k-1].ay[31]) begin
                            n_st[k].cx = y0;
                            n_st[k].cy = -x0;
                            n_st[k].cz = DEG90;
                        end else begin
                            n_st[k].cx = -y0;
                            n_st[k].cy = x0;
                            n_st[k].cz = -DEG90;
                        end
                    end else begin
                        x0 = CW'((r_st[k-1].gprod + 67'sd128) >>> (32 - GUARD));
                        n_st[k].vmode = 1'b0;
                        n_st[k].zvec  = 1'b0;
                        n_st[k].cx    = r_st[k-1].flip ? -x0 : x0;
                        n_st[k].cy    = '0;
                    end
                end

                if (k >= K_C0) begin
                    dx = r_st[k-1].cy >>> (k - K_C0);
                    dy = r_st[k-1].cx >>> (k - K_C0);
                    up = r_st[k-1].vmode ? !r_st[k-1].cy[CW-1] : r_st[k-1].cz[ZW-1];
                    if (up) begin
                        n_st[k].cx = r_st[k-1].cx + dx;
                        n_st[k].cy = r_st[k-1].cy - dy;
                        n_st[k].cz = r_st[k-1].cz + atan_deg(k - K_C0);
                    end else begin
                        n_st[k].cx = r_st[k-1].cx - dx;
                        n_st[k].cy = r_st[k-1].cy + dy;
                        n_st[k].cz = r_st[k-1].cz - atan_deg(k - K_C0);
                    end
                end
            end
        end

        for (k = 1; k <= NS; k++) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[k].valid <= 1'b0;
                end else begin
                    r_st[k].valid <= n_st[k].valid;
                end
                r_st[k].op      <= n_st[k].op;
                r_st[k].ax      <= n_st[k].ax;
                r_st[k].ay      <= n_st[k].ay;
                r_st[k].p0      <= n_st[k].p0;
                r_st[k].p1      <= n_st[k].p1;
                r_st[k].sq_v    <= n_st[k].sq_v;
                r_st[k].sq_r    <= n_st[k].sq_r;
                r_st[k].dqx     <= n_st[k].dqx;
                r_st[k].dqy     <= n_st[k].dqy;
                r_st[k].drx     <= n_st[k].drx;
                r_st[k].dry     <= n_st[k].dry;
                r_st[k].ddx     <= n_st[k].ddx;
                r_st[k].ddy     <= n_st[k].ddy;
                r_st[k].dsx     <= n_st[k].dsx;
                r_st[k].dsy     <= n_st[k].dsy;
                r_st[k].dzx     <= n_st[k].dzx;
                r_st[k].dzy     <= n_st[k].dzy;
                r_st[k].dpx     <= n_st[k].dpx;
                r_st[k].dpy     <= n_st[k].dpy;
                r_st[k].dmx     <= n_st[k].dmx;
                r_st[k].dmy     <= n_st[k].dmy;
                r_st[k].ang_neg <= n_st[k].ang_neg;
                r_st[k].ang_rem <= n_st[k].ang_rem;
                r_st[k].res_x   <= n_st[k].res_x;
                r_st[k].res_y   <= n_st[k].res_y;
                r_st[k].res_dz  <= n_st[k].res_dz;
                r_st[k].gprod   <= n_st[k].gprod;
                r_st[k].flip    <= n_st[k].flip;
                r_st[k].vmode   <= n_st[k].vmode;
                r_st[k].zvec    <= n_st[k].zvec;
                r_st[k].cx      <= n_st[k].cx;
                r_st[k].cy      <= n_st[k].cy;
                r_st[k].cz      <= n_st[k].cz;
            end
        end
    endgenerate

    // result select, rounding and saturation
    always_comb begin
        q_ang = (r_st[NS].cz + ZW'(128)) >>> (GUARD - 16);
        if (q_ang > Q180) begin
            q_ang = q_ang - Q360;
        end else if (q_ang <= -Q180) begin
            q_ang = q_ang + Q360;
        end
        n_out_dz = 1'b0;
        case (r_st[NS].op)
            OP_ADD, OP_SUB, OP_SCALE, OP_MUL, OP_DIVS, OP_DIV: begin
                n_out_x  = r_st[NS].res_x;
                n_out_y  = r_st[NS].res_y;
                n_out_dz = r_st[NS].res_dz;
            end
            OP_TOPOL: begin
                n_out_x = sat32(68'($signed({1'b0, r_st[NS].sq_r[32:0]})));
                n_out_y = r_st[NS].zvec ? 32'sd0 : sat32(68'(q_ang));
            end
            OP_FROMPOL, OP_SETANG: begin
                n_out_x = sat32(68'((r_st[NS].cx + CW'(128)) >>> (GUARD - 16)));
                n_out_y = sat32(68'((r_st[NS].cy + CW'(128)) >>> (GUARD - 16)));
            end
            default: begin
                n_out_x = '0;
                n_out_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_st[NS].valid;
        end
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_dz <= n_out_dz;
    end

    assign o_valid    = r_out_valid;
    assign o_r_x      = r_out_x;
    assign o_r_y      = r_out_y;
    assign o_div_zero = r_out_dz;

endmodule
